// ===== hdl/hq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hq_pkg: shared types and constants of the min-heap queue
// Sizes, operation and status codes, and the command that drives each cell.
// ---------------------------------------------------------------------------
package hq_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // operation codes on the input channel
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef logic signed [KEY_WIDTH-1:0] t_key;

    // command broadcast to every cell of the sorted chain
    typedef struct packed {
        logic ins;
        logic del;
        t_key key;
    } t_cell_cmd;

endpackage

// ===== hdl/hq_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hq_in_if / hq_out_if: valid-ready channels of the min-heap queue
// Operation requests in, status and root results out.
// ---------------------------------------------------------------------------
interface hq_in_if;
    import hq_pkg::*;

    logic valid;
    logic ready;
    logic kind;
    t_key value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface hq_out_if;
    import hq_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       status;
    t_key             root_value;
    logic             root_valid;
    logic [CNT_W-1:0] entry_count;

    modport source (output valid, output status, output root_value,
                    output root_valid, output entry_count, input ready);
    modport sink   (input valid, input status, input root_value,
                    input root_valid, input entry_count, output ready);
endinterface

// ===== hdl/binary_min_heap_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// binary_min_heap_queue: min priority queue of signed keys
// Keys sit in a row of cells kept in ascending order; cell 0 is the minimum.
//
//   channel  dir  handshake      payload
//   i_in     in   valid/ready    kind, value
//   o_res    out  valid/ready    status, root_value, root_valid, entry_count
//
// One item per cycle unless an untaken result stalls it: all cells compare
// and shift at the input transfer edge; the result registers at that edge.
// Reset clears the entry count and the result valid; cell keys are not reset.
// While a result waits untaken, i_in.ready stays low; a result taken in a
// cycle frees the input in that cycle.
// ---------------------------------------------------------------------------
module binary_min_heap_queue import hq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hq_in_if.sink    i_in,
    hq_out_if.source o_res
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_status          r_status;
    t_status          n_status;
    t_key             r_root;
    logic             r_root_valid;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_cmd w_cmd;

    t_key w_key      [CAPACITY];
    t_key w_key_next [CAPACITY];
    logic w_lt       [CAPACITY];

    // accept while no result is held or the held one transfers now
    assign i_in.ready = !r_out_valid || o_res.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    // decode the operation into a chain command
    always_comb begin
        w_cmd.key = i_in.value;
        w_cmd.ins = w_accept && (i_in.kind == KIND_INSERT) && !w_full;
        w_cmd.del = w_accept && (i_in.kind == KIND_DELETE) && !w_empty;
        n_status  = ST_OK;
        if (i_in.kind == KIND_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end
        end else if (w_empty) begin
            n_status = ST_EMPTY;
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // sorted chain of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_key w_left_key;
        logic w_left_lt;
        t_key w_right_key;

        if (g == 0) begin : g_first
            assign w_left_key = '0;
            assign w_left_lt  = 1'b0;
        end else begin : g_mid
            assign w_left_key = w_key[g-1];
            assign w_left_lt  = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_key = w_key[g];
        end else begin : g_inner
            assign w_right_key = w_key[g+1];
        end

        hq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_occupied  (CNT_W'(g) < r_count),
            .i_left_key  (w_left_key),
            .i_left_lt   (w_left_lt),
            .i_right_key (w_right_key),
            .o_key       (w_key[g]),
            .o_lt        (w_lt[g]),
            .o_key_next  (w_key_next[g])
        );
    end

    // hold the entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // result register: load on input transfer, drop on output transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status     <= n_status;
            r_root_valid <= (n_count != '0);
            r_root       <= (n_count != '0) ? w_key_next[0] : '1;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_status;
    assign o_res.root_value  = r_root;
    assign o_res.root_valid  = r_root_valid;
    assign o_res.entry_count = r_count;

endmodule

// ===== hdl/hq_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hq_cell: one slot of the sorted key chain
// Holds one key; on insert it keeps, takes the new key or takes the left
// neighbor's key; on delete it takes the right neighbor's key.
// ---------------------------------------------------------------------------
module hq_cell import hq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  logic      i_occupied,
    input  t_key      i_left_key,
    input  logic      i_left_lt,
    input  t_key      i_right_key,
    output t_key      o_key,
    output logic      o_lt,
    output t_key      o_key_next
);

    t_key r_key;
    t_key n_key;

    // new key goes at or before this slot when the slot is free or larger
    assign o_lt = !i_occupied || (i_cmd.key < r_key);

    // pick the next key: shift right past the insert point, shift left on delete
    always_comb begin
        n_key = r_key;
        if (i_cmd.ins) begin
            if (o_lt) begin
                n_key = i_left_lt ? i_left_key : i_cmd.key;
            end
        end else if (i_cmd.del) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key      = r_key;
    assign o_key_next = n_key;

endmodule

// ===== hdl/hq_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hq_checker: port-level checks of the min-heap queue
// Result consistency and output hold, bound to the top level.
// ---------------------------------------------------------------------------
module hq_checker import hq_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [1:0]       i_status,
    input t_key             i_root_value,
    input logic             i_root_valid,
    input logic [CNT_W-1:0] i_entry_count
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_root_value))
        else $error("result changed while stalled");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_entry_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_root_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_root_valid == (i_entry_count != '0))
        else $error("root valid disagrees with entry count");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_FULL |-> i_entry_count == CNT_W'(CAPACITY))
        else $error("full status with free slots");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_EMPTY
        |-> i_entry_count == '0 && i_root_value == '1)
        else $error("empty status with stored keys");

endmodule

bind binary_min_heap_queue hq_checker u_hq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_status      (o_res.status),
    .i_root_value  (o_res.root_value),
    .i_root_valid  (o_res.root_valid),
    .i_entry_count (o_res.entry_count)
);

// ===== sim/binary_min_heap_queue_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// binary_min_heap_queue_tb: self-checking bench for the min-heap queue
// Drives insert and delete operations through the valid-ready input channel,
// tracks the queue in an array-backed heap of its own and checks status, root
// and entry count of every result transfer, under random idling and a long
// receiver hold-off.
// ---------------------------------------------------------------------------

typedef struct {
    hq_pkg::t_status            status;
    hq_pkg::t_key               root_value;
    logic                       root_valid;
    logic [hq_pkg::CNT_W-1:0]   entry_count;
} t_heap_result;

// Heap of the keys accepted so far and the results still owed by the block
class heap_scoreboard;
    hq_pkg::t_key keys [hq_pkg::CAPACITY];
    int           fill;
    t_heap_result pending [$];
    int           errors;
    int           checked;
    int           full_hits;
    int           empty_hits;
    int           reported;

    function new();
        fill       = 0;
        errors     = 0;
        checked    = 0;
        full_hits  = 0;
        empty_hits = 0;
        reported   = 0;
    endfunction

    function void swap_keys(int a, int b);
        hq_pkg::t_key t;
        t       = keys[a];
        keys[a] = keys[b];
        keys[b] = t;
    endfunction

    // Apply one accepted operation and queue the result it must produce
    function void note_op(logic kind, hq_pkg::t_key value);
        t_heap_result r;
        int           pos;
        int           parent;
        int           left;
        int           right;
        int           best;
        bit           done;
        r.status = hq_pkg::ST_OK;
        if (kind == hq_pkg::KIND_INSERT) begin
            if (fill >= hq_pkg::CAPACITY) begin
                r.status = hq_pkg::ST_FULL;
                full_hits++;
            end else begin
                keys[fill] = value;
                pos = fill;
                fill++;
                // sift up while the parent is strictly greater
                done = 0;
                while (pos != 0 && !done) begin
                    parent = (pos - 1) / 2;
                    if (keys[pos] < keys[parent]) begin
                        swap_keys(pos, parent);
                        pos = parent;
                    end else begin
                        done = 1;
                    end
                end
            end
        end else begin
            if (fill == 0) begin
                r.status = hq_pkg::ST_EMPTY;
                empty_hits++;
            end else begin
                fill--;
                keys[0] = keys[fill];
                // sift down toward the strictly smaller child, left wins ties
                pos  = 0;
                done = 0;
                while (!done) begin
                    left  = 2 * pos + 1;
                    right = 2 * pos + 2;
                    best  = pos;
                    if (left < fill && keys[left] < keys[best])
                        best = left;
                    if (right < fill && keys[right] < keys[best])
                        best = right;
                    if (best == pos) begin
                        done = 1;
                    end else begin
                        swap_keys(pos, best);
                        pos = best;
                    end
                end
            end
        end
        r.root_valid  = (fill > 0);
        r.root_value  = (fill > 0) ? keys[0] : hq_pkg::t_key'(-1);
        r.entry_count = fill[hq_pkg::CNT_W-1:0];
        pending.insert(pending.size(), r);
    endfunction

    function void report(string field, longint exp_v, longint act_v);
        errors++;
        if (reported < 100)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_v, act_v);
        reported++;
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(logic [1:0] status, hq_pkg::t_key root_value,
                               logic root_valid,
                               logic [hq_pkg::CNT_W-1:0] entry_count);
        t_heap_result e;
        if (pending.size() == 0) begin
            errors++;
            $display("%0t ns: result with none expected, expected nothing, actual %0d/%0d",
                     $time, status, root_value);
            return;
        end
        e = pending.pop_front();
        checked++;
        if (status !== e.status)
            report("status", e.status, status);
        if (root_value !== e.root_value)
            report("root_value", e.root_value, root_value);
        if (root_valid !== e.root_valid)
            report("root_valid", e.root_valid, root_valid);
        if (entry_count !== e.entry_count)
            report("entry_count", e.entry_count, entry_count);
    endfunction
endclass

module binary_min_heap_queue_tb;
    import hq_pkg::*;

    localparam int ITEMS     = 2000;
    localparam int HOLD_LEN  = 300;
    localparam int LIMIT     = 400000;

    logic clk;
    logic rst_n;
    int   cycles;
    int   issued;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   hold_requests;

    heap_scoreboard sb = new();

    hq_in_if  in_ch ();
    hq_out_if res_ch ();

    binary_min_heap_queue uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch.sink),
        .o_res   (res_ch.source)
    );

    // Free-running clock, 2 ns period
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Abort a run that hangs
    initial cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("binary_min_heap_queue_tb NOT OK");
            $finish;
        end
    end

    // Pick idle rates by how far the run has come
    function void set_idle_rates(int n);
        if (n < ITEMS / 3) begin
            src_idle_pct = 26;
            snk_idle_pct = 57;
        end else if (n < 2 * ITEMS / 3) begin
            src_idle_pct = 57;
            snk_idle_pct = 26;
        end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
    endfunction

    // Keys weighted toward extremes and a narrow band that forces ties
    function t_key pick_key();
        t_key k;
        case ($urandom_range(0, 7))
            0:       k = t_key'(32'h7fff_ffff);
            1:       k = t_key'(32'h8000_0000);
            2, 3:    k = t_key'($urandom_range(0, 8)) - t_key'(4);
            default: k = t_key'($urandom);
        endcase
        return k;
    endfunction

    // Offer one operation and hold it until the transfer
    task automatic send_op(input logic kind, input t_key value);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.kind  <= kind;
        in_ch.value <= value;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_op(kind, value);
        issued++;
        set_idle_rates(issued);
        // ask the receiver for one long hold-off early in the run
        if (issued == 300)
            hold_requests++;
    endtask

    // Result side: random back-pressure, long hold on request, check transfers
    initial begin
        int hold_left;
        int served;
        hold_left    = 0;
        served       = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_requests != served) begin
                served    = hold_requests;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                sb.check_result(res_ch.status, res_ch.root_value,
                                res_ch.root_valid, res_ch.entry_count);
        end
    end

    // Stimulus
    initial begin
        int   seg;
        int   len;
        int   ins_pct;
        logic kind;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = KIND_INSERT;
        in_ch.value   = '0;
        issued        = 0;
        hold_requests = 0;
        set_idle_rates(0);
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // delete on an empty heap right after reset
        send_op(KIND_DELETE, t_key'(32'h1234_5678));
        // extremes, zero, minus one and repeated keys
        send_op(KIND_INSERT, t_key'(32'h7fff_ffff));
        send_op(KIND_INSERT, t_key'(32'h8000_0000));
        send_op(KIND_INSERT, t_key'(0));
        send_op(KIND_INSERT, t_key'(-1));
        send_op(KIND_INSERT, t_key'(5));
        send_op(KIND_INSERT, t_key'(5));
        send_op(KIND_INSERT, t_key'(5));
        send_op(KIND_INSERT, t_key'(1));
        // drain past empty so the last delete is rejected
        repeat (9)
            send_op(KIND_DELETE, pick_key());

        // random segments: fill bursts reach full, drain bursts reach empty
        while (issued < ITEMS) begin
            seg = $urandom_range(0, 4);
            case (seg)
                0: begin
                    len     = $urandom_range(66, 80);
                    ins_pct = 100;
                end
                1: begin
                    len     = $urandom_range(66, 80);
                    ins_pct = 0;
                end
                2: begin
                    len     = $urandom_range(20, 120);
                    ins_pct = 75;
                end
                3: begin
                    len     = $urandom_range(20, 120);
                    ins_pct = 25;
                end
                default: begin
                    len     = $urandom_range(10, 60);
                    ins_pct = 50;
                end
            endcase
            repeat (len) begin
                kind = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_DELETE;
                send_op(kind, pick_key());
            end
        end
        @(negedge clk);
        in_ch.valid <= 1'b0;

        // drain outstanding results, then allow a few quiet cycles
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d operations checked, %0d inserts rejected on a full heap,",
                 sb.checked, sb.full_hits);
        $display("%0d deletes on an empty heap, %0d mismatches",
                 sb.empty_hits, sb.errors);
        if (sb.errors == 0) begin
            $display("binary_min_heap_queue_tb OK");
        end else begin
            $display("binary_min_heap_queue_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== binary_min_heap_queue.f =====
hdl/hq_pkg.sv
hdl/hq_if.sv
hdl/hq_cell.sv
hdl/binary_min_heap_queue.sv
hdl/hq_checker.sv
sim/binary_min_heap_queue_tb.sv
